// ===== design/slsbq_pkg.sv =====
// ----------------------------------------------------------------------------
// slsbq_pkg
// Shared types and constants of the stereo low-shelf biquad.
// ----------------------------------------------------------------------------
package slsbq_pkg;

  localparam int unsigned NumChannels = 2;    // default history banks
  localparam int unsigned SampleW     = 24;   // Q1.23 audio
  localparam int unsigned CoefW       = 32;   // Q8.24 coefficients
  localparam int unsigned HistW       = 32;   // saturated feedback history
  localparam int unsigned BankW       = 1;    // enough for the largest bank count
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 32;
  localparam int unsigned ChanCountW  = 2;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgB0        = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgB1        = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgB2        = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgA1        = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgA2        = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgChanCount = 3'd5;

  // channel count codes
  localparam logic [ChanCountW-1:0] ChanMono   = 2'd1;
  localparam logic [ChanCountW-1:0] ChanStereo = 2'd2;

  // reset values
  localparam logic signed [CoefW-1:0] CoefOne = 32'sd16777216;

  typedef struct packed {
    logic signed [CoefW-1:0] b0;
    logic signed [CoefW-1:0] b1;
    logic signed [CoefW-1:0] b2;
    logic signed [CoefW-1:0] a1;
    logic signed [CoefW-1:0] a2;
  } slsbq_coef_t;

  // classified sample as queued between front and back
  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      channel;
    logic                      last;
    logic [BankW-1:0]          bank;
    logic                      filt;   // low when channel count is 0 or 3: pass through
  } slsbq_item_t;

endpackage

// ===== design/slsbq_front.sv =====
// ----------------------------------------------------------------------------
// slsbq_front
// Accepts input beats, picks the history bank and filter/bypass, and holds
// them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module slsbq_front import slsbq_pkg::*; #(
  parameter int unsigned CHANNELS = NumChannels
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [SampleW-1:0]    in_sample_i,
  input  logic                  in_channel_i,
  input  logic                  in_last_i,
  input  logic [ChanCountW-1:0] channel_count_i,
  output logic                  item_valid_o,
  output slsbq_item_t           item_o,
  input  logic                  item_pop_i
);

  localparam int unsigned Depth = 2;

  slsbq_item_t queue_q [Depth];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  slsbq_item_t item_in;
  logic        push, pop;

  always_comb begin
    item_in.sample  = $signed(in_sample_i);
    item_in.channel = in_channel_i;
    item_in.last    = in_last_i;
    item_in.filt    = (channel_count_i == ChanMono) || (channel_count_i == ChanStereo);
    item_in.bank    = '0;
    if (channel_count_i == ChanStereo && 32'(in_channel_i) < CHANNELS) begin
      item_in.bank = BankW'(in_channel_i);
    end
  end

  assign in_ready_o   = (count_q != 2'(Depth));
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (count_q != 2'd0);
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

// ===== design/slsbq_back.sv =====
// ----------------------------------------------------------------------------
// slsbq_back
// Biquad datapath: five products, exact sum, floor shift by 24, history
// update and the output register.
// ----------------------------------------------------------------------------
module slsbq_back import slsbq_pkg::*; #(
  parameter int unsigned CHANNELS = NumChannels
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  slsbq_coef_t        coef_i,
  input  logic               item_valid_i,
  input  slsbq_item_t        item_i,
  output logic               item_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SampleW-1:0] out_sample_o,
  output logic               out_channel_o,
  output logic               out_last_o
);

  localparam int unsigned ProdW = 64;
  localparam int unsigned SumW  = ProdW + 2;   // five terms
  localparam int unsigned YW    = SumW - 24;

  logic signed [SampleW-1:0] x1_q [CHANNELS];
  logic signed [SampleW-1:0] x2_q [CHANNELS];
  logic signed [HistW-1:0]   y1_q [CHANNELS];
  logic signed [HistW-1:0]   y2_q [CHANNELS];

  logic                      out_valid_q;
  logic [SampleW-1:0]        out_sample_q, out_sample_d;
  logic                      out_channel_q;
  logic                      out_last_q;

  logic signed [ProdW-1:0]   p_b0, p_b1, p_b2, p_a1, p_a2;
  logic signed [SumW-1:0]    acc;
  logic signed [YW-1:0]      y;
  logic signed [HistW-1:0]   y_sat;
  logic signed [SampleW-1:0] y_clamp;
  logic                      fits32, fits24;
  logic                      step;

  assign step       = item_valid_i && (!out_valid_q || out_ready_i);
  assign item_pop_o = step;

  always_comb begin
    p_b0 = ProdW'(coef_i.b0) * ProdW'(item_i.sample);
    p_b1 = ProdW'(coef_i.b1) * ProdW'(x1_q[item_i.bank]);
    p_b2 = ProdW'(coef_i.b2) * ProdW'(x2_q[item_i.bank]);
    p_a1 = ProdW'(coef_i.a1) * ProdW'(y1_q[item_i.bank]);
    p_a2 = ProdW'(coef_i.a2) * ProdW'(y2_q[item_i.bank]);
    acc  = SumW'(p_b0) + SumW'(p_b1) + SumW'(p_b2) - SumW'(p_a1) - SumW'(p_a2);
    y    = YW'(acc >>> 24);

    fits32 = (y[YW-1:HistW-1] == '0) || (y[YW-1:HistW-1] == '1);
    fits24 = (y[YW-1:SampleW-1] == '0) || (y[YW-1:SampleW-1] == '1);

    if (fits32) begin
      y_sat = y[HistW-1:0];
    end else begin
      y_sat = y[YW-1] ? {1'b1, {(HistW-1){1'b0}}} : {1'b0, {(HistW-1){1'b1}}};
    end
    if (fits24) begin
      y_clamp = y[SampleW-1:0];
    end else begin
      y_clamp = y[YW-1] ? {1'b1, {(SampleW-1){1'b0}}} : {1'b0, {(SampleW-1){1'b1}}};
    end

    out_sample_d = item_i.filt ? y_clamp : item_i.sample;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_sample_q  <= out_sample_d;
      out_channel_q <= item_i.channel;
      out_last_q    <= item_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        x1_q[i] <= '0;
        x2_q[i] <= '0;
        y1_q[i] <= '0;
        y2_q[i] <= '0;
      end
    end else if (step && item_i.filt) begin
      x2_q[item_i.bank] <= x1_q[item_i.bank];
      x1_q[item_i.bank] <= item_i.sample;
      y2_q[item_i.bank] <= y1_q[item_i.bank];
      y1_q[item_i.bank] <= y_sat;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_sample_o  = out_sample_q;
  assign out_channel_o = out_channel_q;
  assign out_last_o    = out_last_q;

endmodule

// ===== design/stereo_low_shelf_biquad_top.sv =====
// ----------------------------------------------------------------------------
// stereo_low_shelf_biquad_top
// Direct-form-1 low-shelf biquad for mono or interleaved stereo Q1.23 audio.
//
//   channel   dir  handshake                       payload
//   s_axis    in   s_axis_tvalid / s_axis_tready   tdata sample, tuser channel,
//                                                  tlast end of buffer
//   m_axis    out  m_axis_tvalid / m_axis_tready   tdata sample, tuser channel,
//                                                  tlast end of buffer
//   cfg       in   cfg_we_i                        cfg_idx_i, cfg_wdata_i
//
// One beat per cycle sustained while m_axis does not stall; a sample is held in
// a queue entry, then the output register. The rate is set by the feedback loop:
// five multiplies, sum and saturation are combinational between history registers.
// Reset clears the history banks and loads b0 = 1.0, other coefficients 0, stereo.
// A two-entry queue parts input and output, so a stalled m_axis fills it
// before s_axis_tready drops.
// ----------------------------------------------------------------------------
module stereo_low_shelf_biquad_top import slsbq_pkg::*; #(
  parameter int unsigned CHANNELS = NumChannels
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,   // [23:0] sample_in
  input  logic [0:0]          s_axis_tuser,   // [0] channel
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata,   // [23:0] sample_out
  output logic [0:0]          m_axis_tuser,   // [0] channel_out
  output logic                m_axis_tlast,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  slsbq_coef_t           coef_q;
  logic [ChanCountW-1:0] chan_count_q;
  logic                  item_valid;
  logic                  item_pop;
  slsbq_item_t           item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.b0    <= CoefOne;
      coef_q.b1    <= '0;
      coef_q.b2    <= '0;
      coef_q.a1    <= '0;
      coef_q.a2    <= '0;
      chan_count_q <= ChanStereo;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgB0:        coef_q.b0    <= $signed(cfg_wdata_i[CoefW-1:0]);
        CfgB1:        coef_q.b1    <= $signed(cfg_wdata_i[CoefW-1:0]);
        CfgB2:        coef_q.b2    <= $signed(cfg_wdata_i[CoefW-1:0]);
        CfgA1:        coef_q.a1    <= $signed(cfg_wdata_i[CoefW-1:0]);
        CfgA2:        coef_q.a2    <= $signed(cfg_wdata_i[CoefW-1:0]);
        CfgChanCount: chan_count_q <= cfg_wdata_i[ChanCountW-1:0];
        default: ;
      endcase
    end
  end

  slsbq_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .in_sample_i     (s_axis_tdata),
    .in_channel_i    (s_axis_tuser[0]),
    .in_last_i       (s_axis_tlast),
    .channel_count_i (chan_count_q),
    .item_valid_o    (item_valid),
    .item_o          (item),
    .item_pop_i      (item_pop)
  );

  slsbq_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .coef_i        (coef_q),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .item_pop_o    (item_pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_sample_o  (m_axis_tdata),
    .out_channel_o (m_axis_tuser[0]),
    .out_last_o    (m_axis_tlast)
  );

endmodule
